### sv/spr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the stepper pulse ramp generator.
// ----------------------------------------------------------------------------
package spr_pkg;

	localparam int PIN_BITS  = 4;
	localparam int REG_BITS  = 16;
	localparam int IDX_BITS  = 3;
	localparam int RIDX_BITS = 3;

	localparam logic [REG_BITS-1:0] RST_CRUISE_HALF_PERIOD = 16'd10;
	localparam logic [REG_BITS-1:0] RST_START_HALF_PERIOD  = 16'd40;
	localparam logic [REG_BITS-1:0] RST_RAMP_STEP          = 16'd1;
	localparam logic                RST_STOP_RELEASES      = 1'b1;
	localparam logic [PIN_BITS-1:0] RST_DIR_FORWARD        = 4'h0;
	localparam logic [PIN_BITS-1:0] RST_DIR_REVERSE        = 4'hf;

	typedef enum logic [RIDX_BITS-1:0] {
		REG_CRUISE_HALF_PERIOD = 3'd0,
		REG_START_HALF_PERIOD  = 3'd1,
		REG_RAMP_STEP          = 3'd2,
		REG_STOP_RELEASES      = 3'd3,
		REG_DIR_FORWARD        = 3'd4,
		REG_DIR_REVERSE        = 3'd5
	} reg_index_t;

	typedef enum logic [1:0] {
		HEAD_STOP = 2'd0,
		HEAD_FWD  = 2'd1,
		HEAD_REV  = 2'd2
	} heading_t;

	typedef struct packed {
		logic [REG_BITS-1:0] cruise_half_period;
		logic [REG_BITS-1:0] start_half_period;
		logic [REG_BITS-1:0] ramp_step;
		logic                stop_releases_driver;
		logic [PIN_BITS-1:0] dir_level_forward;
		logic [PIN_BITS-1:0] dir_level_reverse;
	} cfg_t;

	typedef struct packed {
		logic                command;
		logic [IDX_BITS-1:0] motor_index;
		logic signed [1:0]   direction_request;
	} item_t;

	typedef struct packed {
		logic [PIN_BITS-1:0] step_levels;
		logic [PIN_BITS-1:0] dir_levels;
		logic [PIN_BITS-1:0] enable_levels;
		logic                any_active;
	} result_t;

	typedef struct packed {
		logic     tick;
		logic     addressed;
		heading_t want;
		logic     dir_bit;
	} lane_cmd_t;

	typedef struct packed {
		logic step;
		logic dir;
		logic enable;
		logic running;
	} lane_pins_t;

endpackage

### sv/spr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface spr_item_if;
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic [spr_pkg::IDX_BITS-1:0] motor_index;
	logic signed [1:0]            direction_request;

	modport source (output valid, output command, output motor_index,
		output direction_request, input ready);
	modport sink (input valid, input command, input motor_index,
		input direction_request, output ready);
endinterface

interface spr_result_if;
	logic                         valid;
	logic                         ready;
	logic [spr_pkg::PIN_BITS-1:0] step_levels;
	logic [spr_pkg::PIN_BITS-1:0] dir_levels;
	logic [spr_pkg::PIN_BITS-1:0] enable_levels;
	logic                         any_active;

	modport source (output valid, output step_levels, output dir_levels,
		output enable_levels, output any_active, input ready);
	modport sink (input valid, input step_levels, input dir_levels,
		input enable_levels, input any_active, output ready);
endinterface

interface spr_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [spr_pkg::RIDX_BITS-1:0] reg_index;
	logic [spr_pkg::REG_BITS-1:0]  wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

### sv/stepper_pulse_ramp_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_pulse_ramp_generator_unit
// Step pulse generator with acceleration ramp for up to eight motors.
//
// items carries one beat per timer tick (command 0) or per motor command
// (command 1, motor_index, signed direction_request: 0 stop, >0 forward,
// <0 reverse). results returns one beat per item with the STEP, DIR and
// active-low ENABLE levels of motors 0 to 3 and an any_active flag.
// cfg writes the ramp and pin registers; it is always ready and should be
// written only while no item is in flight.
// An accepted item sits in the input register, all motor lanes update in
// parallel from it, and the result lands in the output register once that
// register is empty or its result is taken. Throughput is one item per
// cycle while results are taken. A stalled result stops the input register
// and the lanes; items keep flowing as long as results are taken.
// Reset: all motors stopped, STEP and DIR low, ENABLE high (driver off),
// half period at the start value, registers at their defaults.
// ----------------------------------------------------------------------------
module stepper_pulse_ramp_generator_unit #(
	parameter int NUM_MOTORS = 4,
	parameter int TICK_WIDTH = 16
) (
	input logic          clk,
	input logic          arst_n,
	spr_item_if.sink     items,
	spr_result_if.source results,
	spr_cfg_if.sink      cfg
);
	import spr_pkg::*;

	cfg_t       regs;
	item_t      item_s1;
	logic       item_valid_s1;
	result_t    res_s2;
	logic       res_valid_s2;
	logic       advance;
	logic       fire;
	heading_t   want;
	lane_cmd_t  lane_cmd [NUM_MOTORS];
	lane_pins_t lane_pins [NUM_MOTORS];
	result_t    res_d;

	spr_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	assign advance     = !res_valid_s2 || results.ready;
	assign fire        = item_valid_s1 && advance;
	assign items.ready = !item_valid_s1 || advance;

	always_comb begin
		unique case (item_s1.direction_request)
			2'sb00:  want = HEAD_STOP;
			2'sb01:  want = HEAD_FWD;
			default: want = HEAD_REV;
		endcase
	end

	for (genvar i = 0; i < NUM_MOTORS; i++) begin : g_lane
		logic dir_bit;
		if (i < PIN_BITS) begin : g_pin
			assign dir_bit = (want == HEAD_FWD) ? regs.dir_level_forward[i]
				: regs.dir_level_reverse[i];
		end else begin : g_nopin
			assign dir_bit = 1'b0;
		end

		assign lane_cmd[i].tick      = fire && !item_s1.command;
		assign lane_cmd[i].addressed = fire && item_s1.command
			&& (item_s1.motor_index == IDX_BITS'(i));
		assign lane_cmd[i].want      = want;
		assign lane_cmd[i].dir_bit   = dir_bit;

		spr_motor_lane #(
			.TICK_WIDTH (TICK_WIDTH)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.regs     (regs),
			.cmd      (lane_cmd[i]),
			.pins_nxt (lane_pins[i])
		);
	end

	always_comb begin
		res_d = '0;
		for (int i = 0; i < NUM_MOTORS; i++) begin
			if (lane_pins[i].running) begin
				res_d.any_active = 1'b1;
			end
		end
		for (int i = 0; i < PIN_BITS; i++) begin
			if (i < NUM_MOTORS) begin
				res_d.step_levels[i]   = lane_pins[i].step;
				res_d.dir_levels[i]    = lane_pins[i].dir;
				res_d.enable_levels[i] = lane_pins[i].enable;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			res_valid_s2  <= 1'b0;
		end else begin
			if (items.ready) begin
				item_valid_s1 <= items.valid;
			end
			if (advance) begin
				res_valid_s2 <= item_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.command           <= items.command;
			item_s1.motor_index       <= items.motor_index;
			item_s1.direction_request <= items.direction_request;
		end
		if (fire) begin
			res_s2 <= res_d;
		end
	end

	assign results.valid         = res_valid_s2;
	assign results.step_levels   = res_s2.step_levels;
	assign results.dir_levels    = res_s2.dir_levels;
	assign results.enable_levels = res_s2.enable_levels;
	assign results.any_active    = res_s2.any_active;

endmodule

### sv/spr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_cfg_regs
// Configuration register file, written one beat at a time.
// ----------------------------------------------------------------------------
module spr_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	spr_cfg_if.sink       cfg,
	output spr_pkg::cfg_t regs
);
	import spr_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.cruise_half_period   <= RST_CRUISE_HALF_PERIOD;
			regs_q.start_half_period    <= RST_START_HALF_PERIOD;
			regs_q.ramp_step            <= RST_RAMP_STEP;
			regs_q.stop_releases_driver <= RST_STOP_RELEASES;
			regs_q.dir_level_forward    <= RST_DIR_FORWARD;
			regs_q.dir_level_reverse    <= RST_DIR_REVERSE;
		end else if (cfg.valid) begin
			unique case (reg_index_t'(cfg.reg_index))
				REG_CRUISE_HALF_PERIOD: regs_q.cruise_half_period <= cfg.wdata;
				REG_START_HALF_PERIOD:  regs_q.start_half_period  <= cfg.wdata;
				REG_RAMP_STEP:          regs_q.ramp_step          <= cfg.wdata;
				REG_STOP_RELEASES:      regs_q.stop_releases_driver <= cfg.wdata[0];
				REG_DIR_FORWARD:        regs_q.dir_level_forward  <= cfg.wdata[PIN_BITS-1:0];
				REG_DIR_REVERSE:        regs_q.dir_level_reverse  <= cfg.wdata[PIN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

### sv/spr_motor_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_motor_lane
// State of one motor: tick counter, STEP toggle, ramp and command handling.
// ----------------------------------------------------------------------------
module spr_motor_lane #(
	parameter int TICK_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  spr_pkg::cfg_t      regs,
	input  spr_pkg::lane_cmd_t cmd,
	output spr_pkg::lane_pins_t pins_nxt
);
	import spr_pkg::*;

	localparam int CMP_W = (TICK_WIDTH > REG_BITS) ? TICK_WIDTH : REG_BITS;

	logic                  running_q, running_d;
	logic                  step_q, step_d;
	logic [TICK_WIDTH-1:0] half_q, half_d;
	logic [TICK_WIDTH-1:0] count_q, count_d;
	heading_t              heading_q, heading_d;
	logic                  dir_q, dir_d;
	logic                  enable_q, enable_d;

	logic [TICK_WIDTH-1:0] count_inc;
	logic [TICK_WIDTH-1:0] cruise;
	logic [TICK_WIDTH-1:0] ramp;
	logic [TICK_WIDTH-1:0] margin;

	assign count_inc = count_q + TICK_WIDTH'(1);
	assign cruise    = TICK_WIDTH'(regs.cruise_half_period);
	assign ramp      = TICK_WIDTH'(regs.ramp_step);
	assign margin    = half_q - cruise;

	always_comb begin
		running_d = running_q;
		step_d    = step_q;
		half_d    = half_q;
		count_d   = count_q;
		heading_d = heading_q;
		dir_d     = dir_q;
		enable_d  = enable_q;
		if (cmd.tick) begin
			if (running_q) begin
				count_d = count_inc;
				if (count_inc >= half_q) begin
					count_d = '0;
					step_d  = !step_q;
					// falling edge ends a full pulse
					if (step_q && half_q > cruise) begin
						if (CMP_W'(margin) > CMP_W'(regs.ramp_step)) begin
							half_d = half_q - ramp;
						end else begin
							half_d = cruise;
						end
					end
				end
			end
		end else if (cmd.addressed) begin
			if (cmd.want == HEAD_STOP) begin
				running_d = 1'b0;
				heading_d = HEAD_STOP;
				enable_d  = regs.stop_releases_driver;
			end else begin
				if (heading_q != cmd.want) begin
					dir_d     = cmd.dir_bit;
					half_d    = TICK_WIDTH'(regs.start_half_period);
					count_d   = '0;
					heading_d = cmd.want;
				end
				enable_d  = 1'b0;
				running_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			step_q    <= 1'b0;
			half_q    <= TICK_WIDTH'(RST_START_HALF_PERIOD);
			count_q   <= '0;
			heading_q <= HEAD_STOP;
			dir_q     <= 1'b0;
			enable_q  <= 1'b1;
		end else begin
			running_q <= running_d;
			step_q    <= step_d;
			half_q    <= half_d;
			count_q   <= count_d;
			heading_q <= heading_d;
			dir_q     <= dir_d;
			enable_q  <= enable_d;
		end
	end

	assign pins_nxt.step    = step_d;
	assign pins_nxt.dir     = dir_d;
	assign pins_nxt.enable  = enable_d;
	assign pins_nxt.running = running_d;

endmodule

### tb/tb_stepper_pulse_ramp_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepper_pulse_ramp_generator_unit
// Self-checking bench for the stepper pulse ramp generator.
//
// A queue of items feeds a driver that offers them on the item channel with
// random gaps. Every accepted beat runs through a behavioral model of the
// four motor lanes (counters, STEP toggling, ramp toward cruise, DIR and
// ENABLE handling), and the pin levels it predicts are queued. A monitor
// compares each result beat field by field with the oldest prediction. The
// run covers directed corner cases, then several register settings with
// mostly ticks and random commands, random receiver stalls, two long stalls
// that back up the input, and sender pauses until the pipe is empty.
// ----------------------------------------------------------------------------
module tb_stepper_pulse_ramp_generator_unit;
	import spr_pkg::*;

	localparam int MOTORS     = 4;
	localparam int LONG_STALL = 80;
	localparam int PHASE_BEATS = 200;

	localparam logic       CMD_TICK  = 1'b0;
	localparam logic       CMD_MOTOR = 1'b1;
	localparam logic [1:0] DIR_STOP  = 2'b00;
	localparam logic [1:0] DIR_FWD   = 2'b01;
	localparam logic [1:0] DIR_REV   = 2'b11;
	localparam logic [1:0] DIR_REV2  = 2'b10;

	localparam int IDLE_NONE   = 0;
	localparam int IDLE_ANY    = 1;
	localparam int IDLE_SPARSE = 2;

	logic clk;
	logic arst_n;

	spr_item_if   items_bus ();
	spr_result_if results_bus ();
	spr_cfg_if    cfg_bus ();

	stepper_pulse_ramp_generator_unit #(
		.NUM_MOTORS(MOTORS),
		.TICK_WIDTH(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_bus),
		.results(results_bus),
		.cfg(cfg_bus)
	);

	// model state
	cfg_t                  shadow_cfg;
	logic                  run_q  [MOTORS];
	logic                  step_q [MOTORS];
	logic [REG_BITS-1:0]   half_q [MOTORS];
	logic [REG_BITS-1:0]   count_q[MOTORS];
	heading_t              head_q [MOTORS];
	logic                  dir_q  [MOTORS];
	logic                  ena_q  [MOTORS];

	item_t   pending_items[$];
	result_t expected_pins[$];

	int mismatches = 0;
	int src_mode   = IDLE_NONE;
	int snk_mode   = IDLE_NONE;
	int src_gap    = 0;
	int sink_wait  = 0;
	bit stall_req  = 0;
	bit item_taken = 0;
	bit result_taken = 0;

	always #5 clk = ~clk;

	function automatic int draw_wait(int mode);
		case (mode)
			IDLE_NONE: return 0;
			IDLE_ANY: return $urandom_range(0, 16);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
		endcase
	endfunction

	function automatic item_t make_item(logic cmd, logic [IDX_BITS-1:0] m, logic [1:0] d);
		item_t it;
		it.command = cmd;
		it.motor_index = m;
		it.direction_request = d;
		return it;
	endfunction

	function automatic item_t random_item(int tick_pct);
		item_t it;
		it.command = ($urandom_range(0, 99) < tick_pct) ? CMD_TICK : CMD_MOTOR;
		if ($urandom_range(0, 9) == 0)
			it.motor_index = IDX_BITS'($urandom_range(4, 7));
		else
			it.motor_index = IDX_BITS'($urandom_range(0, 3));
		it.direction_request = 2'($urandom_range(0, 3));
		return it;
	endfunction

	function automatic void reset_motors();
		shadow_cfg.cruise_half_period   = RST_CRUISE_HALF_PERIOD;
		shadow_cfg.start_half_period    = RST_START_HALF_PERIOD;
		shadow_cfg.ramp_step            = RST_RAMP_STEP;
		shadow_cfg.stop_releases_driver = RST_STOP_RELEASES;
		shadow_cfg.dir_level_forward    = RST_DIR_FORWARD;
		shadow_cfg.dir_level_reverse    = RST_DIR_REVERSE;
		for (int i = 0; i < MOTORS; i++) begin
			run_q[i] = 1'b0;
			step_q[i] = 1'b0;
			half_q[i] = RST_START_HALF_PERIOD;
			count_q[i] = '0;
			head_q[i] = HEAD_STOP;
			dir_q[i] = 1'b0;
			ena_q[i] = 1'b1;
		end
	endfunction

	// updates the motor lanes for one beat and returns the pin levels
	function automatic result_t advance_motors(item_t it);
		result_t r;
		heading_t want;
		logic [REG_BITS-1:0] dec;
		int m;
		r = '0;
		if (it.command == CMD_MOTOR) begin
			if (it.motor_index < MOTORS) begin
				m = int'(it.motor_index);
				if (it.direction_request == DIR_STOP) begin
					run_q[m] = 1'b0;
					head_q[m] = HEAD_STOP;
					ena_q[m] = shadow_cfg.stop_releases_driver;
				end else begin
					want = (it.direction_request == DIR_FWD) ? HEAD_FWD : HEAD_REV;
					if (head_q[m] != want) begin
						dir_q[m] = (want == HEAD_FWD) ? shadow_cfg.dir_level_forward[m]
							: shadow_cfg.dir_level_reverse[m];
						half_q[m] = shadow_cfg.start_half_period;
						count_q[m] = '0;
						head_q[m] = want;
					end
					ena_q[m] = 1'b0;
					run_q[m] = 1'b1;
				end
			end
		end else begin
			for (int i = 0; i < MOTORS; i++) begin
				if (run_q[i]) begin
					count_q[i] = count_q[i] + 1'b1;
					if (count_q[i] >= half_q[i]) begin
						count_q[i] = '0;
						step_q[i] = ~step_q[i];
						if (!step_q[i] && half_q[i] > shadow_cfg.cruise_half_period) begin
							dec = half_q[i] - shadow_cfg.cruise_half_period;
							if (dec > shadow_cfg.ramp_step)
								dec = shadow_cfg.ramp_step;
							half_q[i] = half_q[i] - dec;
						end
					end
				end
			end
		end
		for (int i = 0; i < MOTORS; i++) begin
			r.step_levels[i] = step_q[i];
			r.dir_levels[i] = dir_q[i];
			r.enable_levels[i] = ena_q[i];
			if (run_q[i])
				r.any_active = 1'b1;
		end
		return r;
	endfunction

	task automatic check_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// item driver
	always @(negedge clk) begin
		item_t next_item;
		if (!arst_n) begin
			items_bus.valid <= 1'b0;
			src_gap = 0;
		end else if (!items_bus.valid || item_taken) begin
			if (src_gap > 0) begin
				items_bus.valid <= 1'b0;
				src_gap--;
			end else if (pending_items.size() != 0) begin
				next_item = pending_items.pop_front();
				items_bus.valid <= 1'b1;
				items_bus.command <= next_item.command;
				items_bus.motor_index <= next_item.motor_index;
				items_bus.direction_request <= next_item.direction_request;
				src_gap = draw_wait(src_mode);
			end else begin
				items_bus.valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			results_bus.ready <= 1'b0;
			sink_wait = 0;
		end else begin
			if (result_taken)
				sink_wait = draw_wait(snk_mode);
			if (stall_req) begin
				stall_req = 0;
				sink_wait = LONG_STALL;
			end
			if (sink_wait > 0) begin
				results_bus.ready <= 1'b0;
				sink_wait--;
			end else begin
				results_bus.ready <= 1'b1;
			end
		end
	end

	// monitor: check results, then predict for accepted items
	always @(posedge clk) begin
		item_t in_beat;
		result_t got_pins;
		result_t want_pins;
		item_taken = arst_n && items_bus.valid && items_bus.ready;
		result_taken = arst_n && results_bus.valid && results_bus.ready;
		if (result_taken) begin
			got_pins.step_levels = results_bus.step_levels;
			got_pins.dir_levels = results_bus.dir_levels;
			got_pins.enable_levels = results_bus.enable_levels;
			got_pins.any_active = results_bus.any_active;
			if (expected_pins.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual %h", $time, got_pins);
				mismatches++;
			end else begin
				want_pins = expected_pins.pop_front();
				check_field("step_levels", want_pins.step_levels, got_pins.step_levels);
				check_field("dir_levels", want_pins.dir_levels, got_pins.dir_levels);
				check_field("enable_levels", want_pins.enable_levels, got_pins.enable_levels);
				check_field("any_active", want_pins.any_active, got_pins.any_active);
			end
		end
		if (item_taken) begin
			in_beat.command = items_bus.command;
			in_beat.motor_index = items_bus.motor_index;
			in_beat.direction_request = items_bus.direction_request;
			expected_pins.push_back(advance_motors(in_beat));
		end
	end

	task automatic write_reg(reg_index_t idx, logic [REG_BITS-1:0] val);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.reg_index <= idx;
		cfg_bus.wdata <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_CRUISE_HALF_PERIOD: shadow_cfg.cruise_half_period = val;
			REG_START_HALF_PERIOD: shadow_cfg.start_half_period = val;
			REG_RAMP_STEP: shadow_cfg.ramp_step = val;
			REG_STOP_RELEASES: shadow_cfg.stop_releases_driver = val[0];
			REG_DIR_FORWARD: shadow_cfg.dir_level_forward = val[PIN_BITS-1:0];
			REG_DIR_REVERSE: shadow_cfg.dir_level_reverse = val[PIN_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic wait_for_quiet();
		while (pending_items.size() != 0 || items_bus.valid || expected_pins.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(cfg_t c, int src, int snk, int tick_pct, bit long_stall);
		write_reg(REG_CRUISE_HALF_PERIOD, c.cruise_half_period);
		write_reg(REG_START_HALF_PERIOD, c.start_half_period);
		write_reg(REG_RAMP_STEP, c.ramp_step);
		write_reg(REG_STOP_RELEASES, {15'd0, c.stop_releases_driver});
		write_reg(REG_DIR_FORWARD, {12'd0, c.dir_level_forward});
		write_reg(REG_DIR_REVERSE, {12'd0, c.dir_level_reverse});
		src_mode = src;
		snk_mode = snk;
		repeat (PHASE_BEATS / 2) pending_items.push_back(random_item(tick_pct));
		// sender pauses until the pipe is empty
		wait_for_quiet();
		if (long_stall) begin
			src_mode = IDLE_NONE;
			stall_req = 1;
		end
		repeat (PHASE_BEATS / 2) pending_items.push_back(random_item(tick_pct));
		wait_for_quiet();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		items_bus.valid = 1'b0;
		items_bus.command = CMD_TICK;
		items_bus.motor_index = '0;
		items_bus.direction_request = DIR_STOP;
		results_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.reg_index = REG_CRUISE_HALF_PERIOD;
		cfg_bus.wdata = '0;
		reset_motors();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: start, stop, out of range, fields ignored on ticks
		src_mode = IDLE_SPARSE;
		snk_mode = IDLE_SPARSE;
		pending_items.push_back(make_item(CMD_TICK, 3'd0, DIR_STOP));
		pending_items.push_back(make_item(CMD_MOTOR, 3'd0, DIR_FWD));
		pending_items.push_back(make_item(CMD_MOTOR, 3'd1, DIR_REV));
		pending_items.push_back(make_item(CMD_MOTOR, 3'd2, DIR_REV2));
		pending_items.push_back(make_item(CMD_MOTOR, 3'd5, DIR_FWD));
		pending_items.push_back(make_item(CMD_MOTOR, 3'd7, DIR_STOP));
		pending_items.push_back(make_item(CMD_TICK, 3'd7, DIR_REV2));
		pending_items.push_back(make_item(CMD_MOTOR, 3'd0, DIR_FWD));
		pending_items.push_back(make_item(CMD_MOTOR, 3'd2, DIR_STOP));
		wait_for_quiet();

		// short periods, ramp step larger than the margin
		write_reg(REG_CRUISE_HALF_PERIOD, 16'd1);
		write_reg(REG_START_HALF_PERIOD, 16'd3);
		write_reg(REG_RAMP_STEP, 16'hffff);
		pending_items.push_back(make_item(CMD_MOTOR, 3'd3, DIR_FWD));
		pending_items.push_back(make_item(CMD_MOTOR, 3'd1, DIR_FWD));
		repeat (8) pending_items.push_back(make_item(CMD_TICK, 3'd2, DIR_REV));
		pending_items.push_back(make_item(CMD_MOTOR, 3'd1, DIR_STOP));
		pending_items.push_back(make_item(CMD_TICK, 3'd4, DIR_FWD));
		pending_items.push_back(make_item(CMD_MOTOR, 3'd1, DIR_REV));
		pending_items.push_back(make_item(CMD_MOTOR, 3'd3, DIR_FWD));
		repeat (3) pending_items.push_back(make_item(CMD_TICK, 3'd6, DIR_STOP));
		wait_for_quiet();

		run_phase('{16'd2, 16'd9, 16'd1, 1'b0, 4'h5, 4'ha}, IDLE_NONE, IDLE_NONE, 85, 1'b1);
		run_phase('{16'd1, 16'd1, 16'd0, 1'b1, 4'hf, 4'h0}, IDLE_ANY, IDLE_ANY, 80, 1'b0);
		run_phase('{16'hffff, 16'hffff, 16'hffff, 1'b1, 4'h0, 4'hf},
			IDLE_SPARSE, IDLE_SPARSE, 85, 1'b0);
		run_phase('{16'd20, 16'd6, 16'd3, 1'b0, 4'($urandom_range(0, 15)),
			4'($urandom_range(0, 15))}, IDLE_ANY, IDLE_SPARSE, 85, 1'b1);
		run_phase('{16'd0, 16'd5, 16'd2, 1'b1, 4'($urandom_range(0, 15)),
			4'($urandom_range(0, 15))}, IDLE_SPARSE, IDLE_ANY, 88, 1'b0);
		run_phase('{16'd3, 16'd30, 16'hffff, 1'b0, 4'($urandom_range(0, 15)),
			4'($urandom_range(0, 15))}, IDLE_SPARSE, IDLE_NONE, 95, 1'b0);

		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_pins.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
